/* rtl/core/ffha_pkg.sv */
`default_nettype none
package ffha_pkg;

    // Table geometry and allocator constants.
    localparam int SEG_DEPTH   = 64;
    localparam int IDX_W       = $clog2(SEG_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int OFF_W       = 25;
    localparam int SIZE_W      = 25;
    localparam int HEADER_B    = 12;
    localparam int MIN_SPLIT_B = 16;
    localparam int ALIGN_B     = 8;

    localparam logic [31:0] BASE_RST  = 32'h0100_0000;
    localparam logic [24:0] BYTES_RST = 25'h040_0000;

    // Configuration register indexes.
    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_NULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        logic        mode;
        logic [23:0] request_size;
        logic [31:0] block_address;
    } t_req;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
    } t_resp;

    // One segment table entry.
    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_seg;

    typedef enum logic [1:0] {
        AS_I, AS_I1, AS_JM1, AS_J1
    } t_asel;

    typedef enum logic [1:0] {
        WD_CUR, WD_RDATA, WD_SPLIT, WD_ALLOC
    } t_wsel;

    typedef enum logic [1:0] {
        CUR_HOLD, CUR_LOAD, CUR_LOADFREE, CUR_MERGE
    } t_curop;

    typedef enum logic [2:0] {
        J_HOLD, J_COUNT, J_I1, J_DEC, J_INC
    } t_jop;

    typedef enum logic [1:0] {
        I_HOLD, I_CLR, I_INC
    } t_iop;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_INC, CNT_DEC
    } t_cntop;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    rd;
        t_asel   rd_sel;
        logic    wr;
        t_asel   wr_sel;
        t_wsel   wr_data;
        t_curop  cur_op;
        t_jop    j_op;
        t_iop    i_op;
        t_cntop  cnt_op;
        logic    split_ld;
        logic    res_ld;
        t_status res_status;
        logic    res_addr;
        logic    out_ld;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic zero;
        logic at_end;
        logic pair_end;
        logic fit;
        logic split;
        logic match;
        logic both_free;
        logic j_gt_i1;
        logic j1_lt_cnt;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/core/ffha_ram.sv */
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/ffha_dp.sv */
`default_nettype none
module ffha_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ffha_pkg::t_req       i_in,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output ffha_pkg::t_resp           o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire ffha_pkg::t_cmd       i_cmd,
    output ffha_pkg::t_stat           o_stat
);

    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int SW = ffha_pkg::SIZE_W;

    logic [31:0]         r_base;
    logic [24:0]         r_bytes;
    logic                r_fresh;
    logic                r_rd0;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_j;
    ffha_pkg::t_req      r_req;
    logic [SW-1:0]       r_need;
    logic                r_split;
    ffha_pkg::t_seg      r_cur;
    logic [31:0]         r_res_addr;
    logic [1:0]          r_res_status;
    logic                r_out_valid;
    ffha_pkg::t_resp     r_out;

    logic [CW-1:0]       w_i1;
    logic [CW-1:0]       w_rd_cnt;
    logic [CW-1:0]       w_wr_cnt;
    logic [SW-1:0]       w_need;
    logic [$bits(ffha_pkg::t_seg)-1:0] w_ram_q;
    ffha_pkg::t_seg      w_rdata;
    ffha_pkg::t_seg      w_fresh_seg;
    ffha_pkg::t_seg      w_wdata;
    logic [31:0]         w_rd_pay;
    logic [31:0]         w_cur_pay;

    assign w_i1 = r_i + CW'(1);

    // Request size rounded up to the alignment.
    assign w_need = (SW'(r_req.request_size) + SW'(ffha_pkg::ALIGN_B - 1))
                    & ~SW'(ffha_pkg::ALIGN_B - 1);

    // Entry 0 reads as the initial free segment until it is first written.
    always_comb begin
        w_fresh_seg.off  = '0;
        w_fresh_seg.size = (r_bytes >= 25'(ffha_pkg::HEADER_B)) ?
                           SW'(r_bytes - 25'(ffha_pkg::HEADER_B)) : '0;
        w_fresh_seg.free = 1'b1;
        w_rdata = r_rd0 ? w_fresh_seg : ffha_pkg::t_seg'(w_ram_q);
    end

    // Table address selection.
    always_comb begin
        case (i_cmd.rd_sel)
            ffha_pkg::AS_I:   w_rd_cnt = r_i;
            ffha_pkg::AS_I1:  w_rd_cnt = w_i1;
            ffha_pkg::AS_JM1: w_rd_cnt = r_j - CW'(1);
            ffha_pkg::AS_J1:  w_rd_cnt = r_j + CW'(1);
            default:          w_rd_cnt = r_i;
        endcase
        case (i_cmd.wr_sel)
            ffha_pkg::AS_I:  w_wr_cnt = r_i;
            ffha_pkg::AS_I1: w_wr_cnt = w_i1;
            default:         w_wr_cnt = r_j;
        endcase
    end

    // Write data selection.
    always_comb begin
        case (i_cmd.wr_data)
            ffha_pkg::WD_CUR:   w_wdata = r_cur;
            ffha_pkg::WD_RDATA: w_wdata = w_rdata;
            ffha_pkg::WD_SPLIT: begin
                w_wdata.off  = r_cur.off + ffha_pkg::OFF_W'(ffha_pkg::HEADER_B) + r_need;
                w_wdata.size = r_cur.size - r_need - SW'(ffha_pkg::HEADER_B);
                w_wdata.free = 1'b1;
            end
            default: begin
                w_wdata.off  = r_cur.off;
                w_wdata.size = r_split ? r_need : r_cur.size;
                w_wdata.free = 1'b0;
            end
        endcase
    end

    ffha_ram #(
        .WIDTH ($bits(ffha_pkg::t_seg)),
        .DEPTH (ffha_pkg::SEG_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (w_wr_cnt[IW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (w_rd_cnt[IW-1:0]),
        .o_rdata (w_ram_q)
    );

    // Payload addresses for the entry just read and for the held entry.
    assign w_rd_pay  = r_base + 32'(w_rdata.off) + 32'(ffha_pkg::HEADER_B);
    assign w_cur_pay = r_base + 32'(r_cur.off) + 32'(ffha_pkg::HEADER_B);

    // Status flags for the controller.
    always_comb begin
        o_stat.mode      = r_req.mode;
        o_stat.zero      = (r_req.mode == ffha_pkg::MODE_ALLOC) ?
                           (r_req.request_size == '0) : (r_req.block_address == '0);
        o_stat.at_end    = (r_i >= r_count);
        o_stat.pair_end  = (w_i1 >= r_count);
        o_stat.fit       = w_rdata.free && (w_rdata.size >= r_need);
        o_stat.split     = ({1'b0, w_rdata.size} >= ({1'b0, r_need}
                           + (SW + 1)'(ffha_pkg::HEADER_B + ffha_pkg::MIN_SPLIT_B)))
                           && (r_count < CW'(ffha_pkg::SEG_DEPTH));
        o_stat.match     = (w_rd_pay == r_req.block_address);
        o_stat.both_free = r_cur.free && w_rdata.free;
        o_stat.j_gt_i1   = (r_j > w_i1);
        o_stat.j1_lt_cnt = ((r_j + CW'(1)) < r_count);
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    // Control registers: configuration, fill count, entry-0 mark, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= ffha_pkg::BASE_RST;
            r_bytes     <= ffha_pkg::BYTES_RST;
            r_count     <= CW'(1);
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
                    r_base <= i_cfg_data;
                end else begin
                    r_bytes <= i_cfg_data[24:0];
                end
                r_count <= CW'(1);
                r_fresh <= 1'b1;
            end else begin
                case (i_cmd.cnt_op)
                    ffha_pkg::CNT_INC: r_count <= r_count + CW'(1);
                    ffha_pkg::CNT_DEC: r_count <= r_count - CW'(1);
                    default:           r_count <= r_count;
                endcase
                if (i_cmd.wr && (w_wr_cnt[IW-1:0] == '0)) begin
                    r_fresh <= 1'b0;
                end
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd0 <= r_fresh && (w_rd_cnt[IW-1:0] == '0);
        end
        if (i_cmd.load) begin
            r_req <= i_in;
        end
        r_need <= w_need;
        if (i_cmd.split_ld) begin
            r_split <= o_stat.split;
        end
        case (i_cmd.i_op)
            ffha_pkg::I_CLR: r_i <= '0;
            ffha_pkg::I_INC: r_i <= w_i1;
            default:         r_i <= r_i;
        endcase
        case (i_cmd.j_op)
            ffha_pkg::J_COUNT: r_j <= r_count;
            ffha_pkg::J_I1:    r_j <= w_i1;
            ffha_pkg::J_DEC:   r_j <= r_j - CW'(1);
            ffha_pkg::J_INC:   r_j <= r_j + CW'(1);
            default:           r_j <= r_j;
        endcase
        case (i_cmd.cur_op)
            ffha_pkg::CUR_LOAD: r_cur <= w_rdata;
            ffha_pkg::CUR_LOADFREE: begin
                r_cur.off  <= w_rdata.off;
                r_cur.size <= w_rdata.size;
                r_cur.free <= 1'b1;
            end
            ffha_pkg::CUR_MERGE: begin
                r_cur.size <= r_cur.size + SW'(ffha_pkg::HEADER_B) + w_rdata.size;
            end
            default: r_cur <= r_cur;
        endcase
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_addr   <= i_cmd.res_addr ? w_cur_pay : '0;
        end
        if (i_cmd.out_ld) begin
            r_out.address <= r_res_addr;
            r_out.status  <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

/* rtl/core/ffha_ctrl.sv */
`default_nettype none
module ffha_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP,
        S_A_RD, S_A_CHK, S_A_SH, S_A_SHW, S_A_WR1, S_A_WR2,
        S_F_RD, S_F_CHK, S_F_WR,
        S_M_RD0, S_M_CUR, S_M_NXT, S_M_CHK, S_M_WR, S_M_SH, S_M_SHW,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.i_op = ffha_pkg::I_CLR;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.zero) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ffha_pkg::ST_NULL;
                    n_state          = S_DONE;
                end else if (i_stat.mode == ffha_pkg::MODE_ALLOC) begin
                    n_state = S_A_RD;
                end else begin
                    n_state = S_F_RD;
                end
            end
            // First-fit search.
            S_A_RD: begin
                if (i_stat.at_end) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ffha_pkg::ST_OOM;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::AS_I;
                    n_state      = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (i_stat.fit) begin
                    o_cmd.cur_op   = ffha_pkg::CUR_LOAD;
                    o_cmd.split_ld = 1'b1;
                    o_cmd.j_op     = ffha_pkg::J_COUNT;
                    n_state        = i_stat.split ? S_A_SH : S_A_WR2;
                end else begin
                    o_cmd.i_op = ffha_pkg::I_INC;
                    n_state    = S_A_RD;
                end
            end
            // Open a slot after the chosen segment, moving the tail up.
            S_A_SH: begin
                if (i_stat.j_gt_i1) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::AS_JM1;
                    n_state      = S_A_SHW;
                end else begin
                    n_state = S_A_WR1;
                end
            end
            S_A_SHW: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = ffha_pkg::AS_JM1;
                o_cmd.wr_data = ffha_pkg::WD_RDATA;
                o_cmd.j_op    = ffha_pkg::J_DEC;
                n_state       = S_A_SH;
            end
            S_A_WR1: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = ffha_pkg::AS_I1;
                o_cmd.wr_data = ffha_pkg::WD_SPLIT;
                o_cmd.cnt_op  = ffha_pkg::CNT_INC;
                n_state       = S_A_WR2;
            end
            S_A_WR2: begin
                o_cmd.wr         = 1'b1;
                o_cmd.wr_sel     = ffha_pkg::AS_I;
                o_cmd.wr_data    = ffha_pkg::WD_ALLOC;
                o_cmd.res_ld     = 1'b1;
                o_cmd.res_status = ffha_pkg::ST_OK;
                o_cmd.res_addr   = 1'b1;
                n_state          = S_DONE;
            end
            // Search for the freed payload address.
            S_F_RD: begin
                if (i_stat.at_end) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ffha_pkg::ST_UNKNOWN;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::AS_I;
                    n_state      = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (i_stat.match) begin
                    o_cmd.cur_op = ffha_pkg::CUR_LOADFREE;
                    n_state      = S_F_WR;
                end else begin
                    o_cmd.i_op = ffha_pkg::I_INC;
                    n_state    = S_F_RD;
                end
            end
            S_F_WR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = ffha_pkg::AS_I;
                o_cmd.wr_data = ffha_pkg::WD_CUR;
                o_cmd.i_op    = ffha_pkg::I_CLR;
                n_state       = S_M_RD0;
            end
            // Merge pass over the whole table.
            S_M_RD0: begin
                o_cmd.rd     = 1'b1;
                o_cmd.rd_sel = ffha_pkg::AS_I;
                n_state      = S_M_CUR;
            end
            S_M_CUR: begin
                o_cmd.cur_op = ffha_pkg::CUR_LOAD;
                n_state      = S_M_NXT;
            end
            S_M_NXT: begin
                if (i_stat.pair_end) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = ffha_pkg::ST_OK;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::AS_I1;
                    n_state      = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (i_stat.both_free) begin
                    o_cmd.cur_op = ffha_pkg::CUR_MERGE;
                    o_cmd.j_op   = ffha_pkg::J_I1;
                    n_state      = S_M_WR;
                end else begin
                    o_cmd.cur_op = ffha_pkg::CUR_LOAD;
                    o_cmd.i_op   = ffha_pkg::I_INC;
                    n_state      = S_M_NXT;
                end
            end
            S_M_WR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = ffha_pkg::AS_I;
                o_cmd.wr_data = ffha_pkg::WD_CUR;
                n_state       = S_M_SH;
            end
            // Close the gap left by the absorbed neighbor.
            S_M_SH: begin
                if (i_stat.j1_lt_cnt) begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_sel = ffha_pkg::AS_J1;
                    n_state      = S_M_SHW;
                end else begin
                    o_cmd.cnt_op = ffha_pkg::CNT_DEC;
                    n_state      = S_M_NXT;
                end
            end
            S_M_SHW: begin
                o_cmd.wr      = 1'b1;
                o_cmd.wr_sel  = ffha_pkg::AS_JM1;
                o_cmd.wr_data = ffha_pkg::WD_RDATA;
                o_cmd.j_op    = ffha_pkg::J_INC;
                n_state       = S_M_SH;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

/* rtl/core/first_fit_heap_allocator.sv */
// Sequence: an allocate scans segments in turn, then moves segments up to open a slot;
// a free scans segments in turn, then makes a merge pass over neighbouring pairs and
// moves segments down to close gaps. The segment table holds 64 entries.
// One request is in work at a time; the segment table memory, with one read and one
// write a cycle, sets the pace.
// Reset is synchronous and active low; it and any configuration write leave one free
// segment spanning the heap less one header, with no clearing pass.
`default_nettype none
module first_fit_heap_allocator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire ffha_pkg::t_req  i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output ffha_pkg::t_resp      o_out,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [31:0]     i_cfg_data
);

    ffha_pkg::t_cmd  w_cmd;
    ffha_pkg::t_stat w_stat;

    // Request sequencing.
    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Segment table and arithmetic.
    ffha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule
`default_nettype wire
